@@ src/btm_pkg.sv @@
// Shared types and constants for the box trigger table match block.
// Used by the front, queue, back and top-level modules; depends on nothing.
package btm_pkg;

    localparam int COORD_W    = 32;
    localparam int ZONE_W     = 16;
    localparam int SLOT_W     = 6;
    localparam int CFG_W      = 7;
    localparam int DATA_W     = 32;
    localparam int PADDR_W    = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;

    // Register index of entries_in_use, taken from paddr[PADDR_W-1:2].
    localparam logic [PADDR_W-3:0] REG_ENTRIES = 1'b0;

    // Stored destination magnitudes at or above this (999998.0 in Q23.8) mean
    // "keep the current coordinate".
    localparam logic [COORD_W-1:0] MARK_LIMIT = 32'd255999488;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [1:0]
    {
        OP_BOUNDS = 2'd0,
        OP_DEST   = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } scan_state_t;

    typedef struct packed
    {
        op_t                op;
        logic [SLOT_W-1:0]  slot;
        coord_t             v0;
        coord_t             v1;
        coord_t             v2;
        coord_t             v3;
        coord_t             v4;
        coord_t             v5;
        logic [ZONE_W-1:0]  zone;
        logic [ZONE_W-1:0]  point;
    } item_t;

    typedef struct packed
    {
        coord_t             min_x;
        coord_t             max_x;
        coord_t             min_y;
        coord_t             max_y;
        coord_t             min_z;
        coord_t             max_z;
        logic [ZONE_W-1:0]  zone;
        logic [ZONE_W-1:0]  point;
    } bnd_row_t;

    typedef struct packed
    {
        coord_t x;
        coord_t y;
        coord_t z;
        coord_t heading;
    } dst_row_t;

    typedef struct packed
    {
        logic               hit;
        logic [ZONE_W-1:0]  zone;
        logic [ZONE_W-1:0]  point;
        coord_t             x;
        coord_t             y;
        coord_t             z;
        coord_t             heading;
    } result_t;

    // Returns the current coordinate when the stored one carries the marker.
    function automatic coord_t pick_coord(input coord_t dest, input coord_t cur);
        logic [COORD_W-1:0] mag;
        mag = dest[COORD_W-1] ? (~dest + COORD_W'(1)) : dest;
        return (mag >= MARK_LIMIT) ? cur : dest;
    endfunction

endpackage

@@ src/box_trigger_table_match_top.sv @@
// Box trigger table match: first-match point-in-box lookup over a loaded table.
// Writes are applied in order by the scan engine; a query scans entries 0 to N - 1,
// N = min(entries_in_use, ENTRIES), and stops at the first entry that matches. A result
// is held until the output register is free; the next request starts once the scan
// engine is idle.
// Reset clears control state and entries_in_use; table contents are undefined until written.
module box_trigger_table_match_top #(
    parameter int ENTRIES = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [btm_pkg::PADDR_W-1:0]         paddr,
    input  logic [btm_pkg::DATA_W-1:0]          pwdata,
    output logic [btm_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic [1:0]                          opcode,
    input  logic [btm_pkg::SLOT_W-1:0]          slot,
    input  logic signed [btm_pkg::COORD_W-1:0]  value_0,
    input  logic signed [btm_pkg::COORD_W-1:0]  value_1,
    input  logic signed [btm_pkg::COORD_W-1:0]  value_2,
    input  logic signed [btm_pkg::COORD_W-1:0]  value_3,
    input  logic signed [btm_pkg::COORD_W-1:0]  value_4,
    input  logic signed [btm_pkg::COORD_W-1:0]  value_5,
    input  logic [btm_pkg::ZONE_W-1:0]          zone_id,
    input  logic [btm_pkg::ZONE_W-1:0]          zone_point,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic                                hit,
    output logic [btm_pkg::ZONE_W-1:0]          match_zone,
    output logic [btm_pkg::ZONE_W-1:0]          target_point,
    output logic signed [btm_pkg::COORD_W-1:0]  target_x,
    output logic signed [btm_pkg::COORD_W-1:0]  target_y,
    output logic signed [btm_pkg::COORD_W-1:0]  target_z,
    output logic signed [btm_pkg::COORD_W-1:0]  target_heading
);

    logic [btm_pkg::CFG_W-1:0]  entries_in_use_reg, entries_in_use_next;
    logic                       reg_sel;
    logic                       push_valid;
    logic                       push_ready;
    btm_pkg::item_t             push_item;
    logic                       q_valid;
    logic                       q_pop;
    btm_pkg::item_t             q_item;
    btm_pkg::result_t           result;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[btm_pkg::PADDR_W-1:2] == btm_pkg::REG_ENTRIES);
    assign prdata  = reg_sel ? btm_pkg::DATA_W'(entries_in_use_reg) : '0;

    always_comb
    begin
        entries_in_use_next = entries_in_use_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            entries_in_use_next = pwdata[btm_pkg::CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_in_use_reg <= '0;
        end
        else
        begin
            entries_in_use_reg <= entries_in_use_next;
        end
    end

    btm_front #(
        .ENTRIES(ENTRIES)
    ) u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .opcode     (opcode),
        .slot       (slot),
        .value_0    (value_0),
        .value_1    (value_1),
        .value_2    (value_2),
        .value_3    (value_3),
        .value_4    (value_4),
        .value_5    (value_5),
        .zone_id    (zone_id),
        .zone_point (zone_point),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    btm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (q_valid),
        .pop_item   (q_item),
        .pop        (q_pop)
    );

    btm_back #(
        .ENTRIES(ENTRIES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .entries_in_use (entries_in_use_reg),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result         (result)
    );

    assign hit            = result.hit;
    assign match_zone     = result.zone;
    assign target_point   = result.point;
    assign target_x       = result.x;
    assign target_y       = result.y;
    assign target_z       = result.z;
    assign target_heading = result.heading;

endmodule

@@ src/btm_front.sv @@
// Front end: takes input requests, drops unused opcodes and out-of-range
// writes, and packs the rest for the queue. Depends on btm_pkg.
module btm_front #(
    parameter int ENTRIES = 64
) (
    input  logic                             item_valid,
    output logic                             item_ready,
    input  logic [1:0]                       opcode,
    input  logic [btm_pkg::SLOT_W-1:0]       slot,
    input  logic signed [btm_pkg::COORD_W-1:0] value_0,
    input  logic signed [btm_pkg::COORD_W-1:0] value_1,
    input  logic signed [btm_pkg::COORD_W-1:0] value_2,
    input  logic signed [btm_pkg::COORD_W-1:0] value_3,
    input  logic signed [btm_pkg::COORD_W-1:0] value_4,
    input  logic signed [btm_pkg::COORD_W-1:0] value_5,
    input  logic [btm_pkg::ZONE_W-1:0]       zone_id,
    input  logic [btm_pkg::ZONE_W-1:0]       zone_point,
    output logic                             push_valid,
    output btm_pkg::item_t                   push_item,
    input  logic                             push_ready
);

    logic slot_ok;
    logic keep;

    assign slot_ok = ({26'b0, slot} < 32'(ENTRIES));

    always_comb
    begin
        unique case (opcode)
            btm_pkg::OP_BOUNDS: keep = slot_ok;
            btm_pkg::OP_DEST:   keep = slot_ok;
            btm_pkg::OP_QUERY:  keep = 1'b1;
            default:            keep = 1'b0;
        endcase
    end

    always_comb
    begin
        push_item.op    = btm_pkg::op_t'(opcode);
        push_item.slot  = slot;
        push_item.v0    = value_0;
        push_item.v1    = value_1;
        push_item.v2    = value_2;
        push_item.v3    = value_3;
        push_item.v4    = value_4;
        push_item.v5    = value_5;
        push_item.zone  = zone_id;
        push_item.point = zone_point;
    end

    // Dropped requests are still taken; they just never reach the queue.
    assign item_ready = push_ready;
    assign push_valid = item_valid && keep;

endmodule

@@ src/btm_queue.sv @@
// Short request queue between the front end and the scan engine.
// Depends on btm_pkg for the request type and depth.
module btm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  btm_pkg::item_t push_item,
    output logic           push_ready,
    output logic           pop_valid,
    output btm_pkg::item_t pop_item,
    input  logic           pop
);

    btm_pkg::item_t                 slot_reg [btm_pkg::QUEUE_DEPTH];
    logic [btm_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [btm_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [btm_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                           do_push;
    logic                           do_pop;

    assign push_ready = (count_reg != btm_pkg::QCNT_W'(btm_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + btm_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + btm_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + btm_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - btm_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ src/btm_back.sv @@
// Scan engine: holds the box table, applies writes in order and scans it for
// queries, one entry read per cycle, into an output register. Depends on btm_pkg.
module btm_back #(
    parameter int ENTRIES = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [btm_pkg::CFG_W-1:0]   entries_in_use,
    input  logic                        q_valid,
    input  btm_pkg::item_t              q_item,
    output logic                        q_pop,
    output logic                        result_valid,
    input  logic                        result_ready,
    output btm_pkg::result_t            result
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int LIM_W = (CNT_W > btm_pkg::CFG_W) ? CNT_W : btm_pkg::CFG_W;

    btm_pkg::bnd_row_t      bnd_mem [ENTRIES];
    btm_pkg::dst_row_t      dst_mem [ENTRIES];
    btm_pkg::bnd_row_t      bnd_rd_reg;
    btm_pkg::dst_row_t      dst_rd_reg;

    btm_pkg::scan_state_t   state_reg, state_next;
    logic [CNT_W-1:0]       addr_reg, addr_next;
    logic [CNT_W-1:0]       n_reg, n_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic                   out_valid_reg, out_valid_next;
    btm_pkg::item_t         qry_reg;
    btm_pkg::result_t       res_reg;
    btm_pkg::result_t       out_reg;

    logic                   bnd_we;
    logic                   dst_we;
    logic                   qry_load;
    logic                   rd_en;
    logic                   found;
    logic                   missed;
    logic                   out_free;
    logic                   out_load;
    logic                   in_box;
    logic [IDX_W-1:0]       wr_addr;
    logic [LIM_W-1:0]       cfg_ext;
    btm_pkg::result_t       hit_res;

    assign wr_addr  = IDX_W'(q_item.slot);
    assign cfg_ext  = LIM_W'(entries_in_use);
    assign out_free = !out_valid_reg || result_ready;

    // Inclusive signed bounds on all three axes.
    assign in_box = ($signed(bnd_rd_reg.min_x) <= $signed(qry_reg.v0))
                 && ($signed(qry_reg.v0) <= $signed(bnd_rd_reg.max_x))
                 && ($signed(bnd_rd_reg.min_y) <= $signed(qry_reg.v1))
                 && ($signed(qry_reg.v1) <= $signed(bnd_rd_reg.max_y))
                 && ($signed(bnd_rd_reg.min_z) <= $signed(qry_reg.v2))
                 && ($signed(qry_reg.v2) <= $signed(bnd_rd_reg.max_z));

    always_comb
    begin
        hit_res.hit     = 1'b1;
        hit_res.zone    = bnd_rd_reg.zone;
        hit_res.point   = bnd_rd_reg.point;
        hit_res.x       = btm_pkg::pick_coord(dst_rd_reg.x, qry_reg.v3);
        hit_res.y       = btm_pkg::pick_coord(dst_rd_reg.y, qry_reg.v4);
        hit_res.z       = btm_pkg::pick_coord(dst_rd_reg.z, qry_reg.v5);
        hit_res.heading = dst_rd_reg.heading;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            btm_pkg::ST_IDLE:
            begin
                if (q_valid && q_item.op == btm_pkg::OP_QUERY)
                begin
                    state_next = btm_pkg::ST_SCAN;
                end
            end
            btm_pkg::ST_SCAN:
            begin
                if (found || missed)
                begin
                    state_next = btm_pkg::ST_DONE;
                end
            end
            btm_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = btm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = btm_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs of the state machine.
    always_comb
    begin
        q_pop    = 1'b0;
        rd_en    = 1'b0;
        found    = 1'b0;
        missed   = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            btm_pkg::ST_IDLE:
            begin
                q_pop = q_valid;
            end
            btm_pkg::ST_SCAN:
            begin
                rd_en  = (addr_reg != n_reg);
                found  = rd_vld_reg && in_box;
                missed = !rd_vld_reg && (addr_reg == n_reg);
            end
            btm_pkg::ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    assign bnd_we   = q_pop && (q_item.op == btm_pkg::OP_BOUNDS);
    assign dst_we   = q_pop && (q_item.op == btm_pkg::OP_DEST);
    assign qry_load = q_pop && (q_item.op == btm_pkg::OP_QUERY);

    always_comb
    begin
        addr_next = addr_reg;
        n_next    = n_reg;
        if (qry_load)
        begin
            addr_next = '0;
            n_next    = (cfg_ext > LIM_W'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(cfg_ext);
        end
        else if (rd_en)
        begin
            addr_next = addr_reg + CNT_W'(1);
        end
        // A read already in flight when a match lands is discarded.
        rd_vld_next = rd_en && !found;

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= btm_pkg::ST_IDLE;
            addr_reg      <= '0;
            n_reg         <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            n_reg         <= n_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bnd_we)
        begin
            bnd_mem[wr_addr] <= '{min_x: q_item.v0, max_x: q_item.v1,
                                  min_y: q_item.v2, max_y: q_item.v3,
                                  min_z: q_item.v4, max_z: q_item.v5,
                                  zone: q_item.zone, point: q_item.point};
        end
        if (dst_we)
        begin
            dst_mem[wr_addr] <= '{x: q_item.v0, y: q_item.v1,
                                  z: q_item.v2, heading: q_item.v3};
        end
        if (rd_en)
        begin
            bnd_rd_reg <= bnd_mem[addr_reg[IDX_W-1:0]];
            dst_rd_reg <= dst_mem[addr_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (qry_load)
        begin
            qry_reg <= q_item;
        end
        if (found)
        begin
            res_reg <= hit_res;
        end
        else if (missed)
        begin
            res_reg <= '0;
        end
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
